FILE: rtl/fat_pkg.sv
// ----------------------------------------------------------------------------
// fat_pkg
// Types and codes shared by the fragment ack status table and its cell ring.
// ----------------------------------------------------------------------------
package fat_pkg;

    localparam int CFG_W      = 7;   // fragment_count register width
    localparam int FRAG_IDX_W = 6;   // fragment index field width
    localparam int CNT_OUT_W  = 7;   // count fields in a result
    localparam int LIST_LIMIT = 64;  // most results one list command gives
    localparam int LIST_CNT_W = 7;   // holds 0..LIST_LIMIT

    // command opcodes
    localparam logic [1:0] OP_SET        = 2'd0;
    localparam logic [1:0] OP_RESET_SENT = 2'd1;
    localparam logic [1:0] OP_LIST       = 2'd2;
    localparam logic [1:0] OP_QUERY      = 2'd3;

    // status codes for a set command
    localparam logic [1:0] STAT_UNSENT = 2'd0;
    localparam logic [1:0] STAT_SENT   = 2'd1;
    localparam logic [1:0] STAT_ACKED  = 2'd2;
    localparam logic [1:0] STAT_NACKED = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [1:0]            new_status;
        logic [FRAG_IDX_W-1:0] fragment_index;
    } cmd_item_t;

    typedef struct packed {
        logic [FRAG_IDX_W-1:0] listed_index;
        logic                  index_valid;
        logic                  last_result;
        logic                  accepted;
        logic [CNT_OUT_W-1:0]  not_acked_total;
        logic [CNT_OUT_W-1:0]  acked_total;
        logic [CNT_OUT_W-1:0]  sent_total;
        logic [CNT_OUT_W-1:0]  unsent_total;
        logic [FRAG_IDX_W-1:0] last_sent;
        logic [FRAG_IDX_W-1:0] highest_sent;
    } rsp_item_t;

    // per-fragment flag pair held in one cell
    typedef struct packed {
        logic sent;
        logic acked;
    } frag_flags_t;

endpackage

FILE: rtl/fat_cell.sv
// ----------------------------------------------------------------------------
// fat_cell
// One fragment's sent/acked flags; loads its neighbor's flags on shift.
// ----------------------------------------------------------------------------
module fat_cell
    import fat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  frag_flags_t flags_in,
    output frag_flags_t flags
);

    frag_flags_t flags_reg;
    frag_flags_t flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (shift)
        begin
            flags_next = flags_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

FILE: rtl/fat_ring.sv
// ----------------------------------------------------------------------------
// fat_ring
// Ring of flag cells. Each shift moves every cell one place toward the head;
// the tail takes the (possibly updated) head flags written back by control.
// ----------------------------------------------------------------------------
module fat_ring
    import fat_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  frag_flags_t tail_in,
    output frag_flags_t head
);

    frag_flags_t cell_flags [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        frag_flags_t cell_in;

        if (i == DEPTH - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_body
            assign cell_in = cell_flags[i+1];
        end

        fat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .flags_in (cell_in),
            .flags    (cell_flags[i])
        );
    end

    assign head = cell_flags[0];

endmodule

FILE: rtl/fragment_ack_status_table.sv
// ----------------------------------------------------------------------------
// fragment_ack_status_table
// Per-fragment sent/acked tracking for one sample, with list and count.
// ----------------------------------------------------------------------------
// Flow: a command is taken when idle and walks the ring once, applying the
//   command and counting flags; its result is then registered once the
//   output is free. A list command with unsent fragments walks the ring a
//   second time instead and emits unsent indices as they reach the head,
//   pausing the ring while the output stalls.
// Commands: a new command is taken only once the last is through, as set by
//   the rotation of the flag ring through the head.
// Reset: all flags, last/highest sent cleared; fragment_count reads 64.
// ----------------------------------------------------------------------------
module fragment_ack_status_table
    import fat_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_item_t        cmd,
    // result channel
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp,
    // fragment_count register
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data
);

    // position counter, count accumulators, common compare width
    localparam int PW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int CW = $clog2(MAX_FRAGMENTS + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_FRAGMENTS - 1);

    // controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;  // apply command, count flags
    localparam logic [1:0] S_LIST  = 2'd2;  // second turn: emit unsent indices
    localparam logic [1:0] S_REPLY = 2'd3;  // single result of a non-list cmd, or of a list with nothing to list

    logic [1:0]            state_reg,        state_next;
    logic [PW-1:0]         pos_reg,          pos_next;
    cmd_item_t             cmd_reg,          cmd_next;
    logic                  set_ok_reg,       set_ok_next;
    logic [CW-1:0]         na_reg,           na_next;
    logic [CW-1:0]         ak_reg,           ak_next;
    logic [CW-1:0]         st_reg,           st_next;
    logic [CW-1:0]         us_reg,           us_next;
    logic [LIST_CNT_W-1:0] k_reg,            k_next;
    logic [LIST_CNT_W-1:0] limit_reg,        limit_next;
    logic [FRAG_IDX_W-1:0] last_sent_reg,    last_sent_next;
    logic [FRAG_IDX_W-1:0] highest_sent_reg, highest_sent_next;
    logic [CFG_W-1:0]      frag_count_reg,   frag_count_next;
    logic                  rsp_valid_reg,    rsp_valid_next;
    rsp_item_t             rsp_reg,          rsp_next;

    frag_flags_t head;
    frag_flags_t head_upd;
    logic        ring_shift;
    logic [NW-1:0] n_eff;
    logic        in_range;
    logic        rsp_free;
    logic        found;
    logic [CW-1:0] na_walk;
    rsp_item_t   rsp_base;

    fat_ring #(
        .DEPTH (MAX_FRAGMENTS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (ring_shift),
        .tail_in (head_upd),
        .head    (head)
    );

    // a count above capacity acts as full capacity
    assign n_eff = (NW'(frag_count_reg) > NW'(MAX_FRAGMENTS)) ?
                   NW'(MAX_FRAGMENTS) : NW'(frag_count_reg);

    assign in_range = NW'(pos_reg) < n_eff;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // flags of the head fragment after this command
    always_comb
    begin
        head_upd = head;
        if (state_reg == S_WALK && in_range)
        begin
            case (cmd_reg.opcode)
                OP_SET:
                begin
                    if (set_ok_reg &&
                        NW'(cmd_reg.fragment_index) == NW'(pos_reg))
                    begin
                        case (cmd_reg.new_status)
                            STAT_SENT:  head_upd = '{sent: 1'b1, acked: 1'b0};
                            STAT_ACKED: head_upd = '{sent: 1'b1, acked: 1'b1};
                            default:    head_upd = '{sent: 1'b0, acked: 1'b0};
                        endcase
                    end
                end
                OP_RESET_SENT:
                begin
                    if (head.sent && !head.acked)
                    begin
                        head_upd = '{sent: 1'b0, acked: 1'b0};
                    end
                end
                default:
                begin
                    head_upd = head;
                end
            endcase
        end
    end

    // an unsent fragment at the head during the list turn, below the list limit
    assign found = (state_reg == S_LIST) && in_range &&
                   !head.sent && !head.acked && (k_reg < limit_reg);

    // the ring moves only in the walk and list turns, pausing when a listed index cannot be handed out yet
    assign ring_shift = (state_reg == S_WALK) ||
                        (state_reg == S_LIST && !(found && !rsp_free));

    // not-acked count including the fragment at the head this cycle
    assign na_walk = na_reg +
                     CW'(in_range && !head_upd.sent && !head_upd.acked);

    // fields every result shares
    always_comb
    begin
        rsp_base.listed_index    = '0;
        rsp_base.index_valid     = 1'b0;
        rsp_base.last_result     = 1'b1;
        rsp_base.accepted        = 1'b1;
        rsp_base.not_acked_total = CNT_OUT_W'(na_reg);
        rsp_base.acked_total     = CNT_OUT_W'(ak_reg);
        rsp_base.sent_total      = CNT_OUT_W'(st_reg);
        rsp_base.unsent_total    = CNT_OUT_W'(us_reg);
        rsp_base.last_sent       = last_sent_reg;
        rsp_base.highest_sent    = highest_sent_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        cmd_next          = cmd_reg;
        set_ok_next       = set_ok_reg;
        na_next           = na_reg;
        ak_next           = ak_reg;
        st_next           = st_reg;
        us_next           = us_reg;
        k_next            = k_reg;
        limit_next        = limit_reg;
        last_sent_next    = last_sent_reg;
        highest_sent_next = highest_sent_reg;
        frag_count_next   = frag_count_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_next          = rsp_reg;

        if (cfg_write_en)
        begin
            frag_count_next = cfg_write_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    set_ok_next = NW'(cmd.fragment_index) < n_eff;
                    pos_next    = '0;
                    na_next     = '0;
                    ak_next     = '0;
                    st_next     = '0;
                    us_next     = '0;
                    // sent marks are bookkept at accept time
                    if (cmd.opcode == OP_SET && cmd.new_status == STAT_SENT &&
                        NW'(cmd.fragment_index) < n_eff)
                    begin
                        last_sent_next = cmd.fragment_index;
                        if (cmd.fragment_index > highest_sent_reg)
                        begin
                            highest_sent_next = cmd.fragment_index;
                        end
                    end
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (in_range)
                begin
                    na_next = na_walk;
                    ak_next = ak_reg + CW'(head_upd.acked);
                    st_next = st_reg + CW'(head_upd.sent || head_upd.acked);
                    us_next = us_reg + CW'(!head_upd.sent);
                end
                if (pos_reg == POS_LAST)
                begin
                    pos_next = '0;
                    k_next   = '0;
                    limit_next = (NW'(na_walk) > NW'(LIST_LIMIT)) ?
                                 LIST_CNT_W'(LIST_LIMIT) : LIST_CNT_W'(na_walk);
                    if (cmd_reg.opcode == OP_LIST && na_walk != '0)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                end
            end

            S_LIST:
            begin
                if (ring_shift)
                begin
                    if (found)
                    begin
                        rsp_next              = rsp_base;
                        rsp_next.listed_index = FRAG_IDX_W'(pos_reg);
                        rsp_next.index_valid  = 1'b1;
                        rsp_next.last_result  = (k_reg == limit_reg - LIST_CNT_W'(1));
                        rsp_valid_next        = 1'b1;
                        k_next                = k_reg + LIST_CNT_W'(1);
                    end
                    if (pos_reg == POS_LAST)
                    begin
                        pos_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end

            S_REPLY:
            begin
                if (rsp_free)
                begin
                    rsp_next          = rsp_base;
                    rsp_next.accepted = (cmd_reg.opcode != OP_SET) || set_ok_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pos_reg          <= '0;
            cmd_reg          <= '0;
            set_ok_reg       <= 1'b0;
            na_reg           <= '0;
            ak_reg           <= '0;
            st_reg           <= '0;
            us_reg           <= '0;
            k_reg            <= '0;
            limit_reg        <= '0;
            last_sent_reg    <= '0;
            highest_sent_reg <= '0;
            frag_count_reg   <= CFG_W'(64);
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            cmd_reg          <= cmd_next;
            set_ok_reg       <= set_ok_next;
            na_reg           <= na_next;
            ak_reg           <= ak_next;
            st_reg           <= st_next;
            us_reg           <= us_next;
            k_reg            <= k_next;
            limit_reg        <= limit_next;
            last_sent_reg    <= last_sent_next;
            highest_sent_reg <= highest_sent_next;
            frag_count_reg   <= frag_count_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_reg          <= rsp_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: test/fragment_ack_status_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fragment_ack_status_table_tb
// Self-checking bench: a directed command table, then random phases under
// several fragment counts, with bursty commands and a stalling receiver. Every
// result is compared field by field against an in-bench status tracker or a hand-written result.
// ----------------------------------------------------------------------------
module fragment_ack_status_table_tb;
    import fat_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    // a list walks the ring twice; leave room for that plus slack
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // one row of the directed table: a count write or a command
    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] count;
        cmd_item_t        c;
        bit               typed;   // want holds a hand-written result
        rsp_item_t        want;
    } step_t;

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_stall;
    cmd_item_t        cmd;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_item_t        rsp;
    logic             cfg_write_en;
    logic [CFG_W-1:0] cfg_write_data;

    fragment_ack_status_table #(
        .MAX_FRAGMENTS (TABLE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // ------------------------------------------------------------------
    // Tracker state: the bench's own copy of the flag table
    // ------------------------------------------------------------------
    bit                    frag_sent [TABLE_DEPTH];
    bit                    frag_acked[TABLE_DEPTH];
    logic [FRAG_IDX_W-1:0] track_last_sent;
    logic [FRAG_IDX_W-1:0] track_highest_sent;
    logic [CFG_W-1:0]      track_count;

    rsp_item_t   expected_reports[$];
    step_t       steps[$];
    int          fault_count = 0;
    longint      cycle_count = 0;
    int unsigned hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // counts above capacity act as full capacity
    function automatic int unsigned live_fragments();
        return (int'(track_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(track_count);
    endfunction

    // one result: the counts are taken over the live fragments only
    function automatic rsp_item_t status_report(logic [FRAG_IDX_W-1:0] idx,
                                                logic valid, logic last, logic acc);
        rsp_item_t   r;
        int unsigned n;
        n = live_fragments();
        r = '0;
        r.listed_index = idx;
        r.index_valid  = valid;
        r.last_result  = last;
        r.accepted     = acc;
        for (int i = 0; i < n; i++)
        begin
            if (!frag_sent[i] && !frag_acked[i])
                r.not_acked_total = r.not_acked_total + CNT_OUT_W'(1);
            if (frag_acked[i])
                r.acked_total = r.acked_total + CNT_OUT_W'(1);
            if (frag_sent[i] || frag_acked[i])
                r.sent_total = r.sent_total + CNT_OUT_W'(1);
            if (!frag_sent[i])
                r.unsent_total = r.unsent_total + CNT_OUT_W'(1);
        end
        r.last_sent    = track_last_sent;
        r.highest_sent = track_highest_sent;
        return r;
    endfunction

    // append one result to a queue of booked results
    function automatic void add_report(ref rsp_item_t q[$], input rsp_item_t r);
        q = {q, r};
    endfunction

    // apply one command to the tracker and return the results it causes
    function automatic void apply_command(input cmd_item_t c, ref rsp_item_t reports[$]);
        int unsigned n;
        int unsigned idx;
        int          found[$];
        n   = live_fragments();
        idx = int'(c.fragment_index);
        reports.delete();
        case (c.opcode)
            OP_SET:
            begin
                if (idx >= n)
                    add_report(reports, status_report('0, 1'b0, 1'b1, 1'b0));
                else
                begin
                    case (c.new_status)
                        STAT_SENT:
                        begin
                            track_last_sent = c.fragment_index;
                            frag_sent[idx]  = 1'b1;
                            frag_acked[idx] = 1'b0;
                            if (c.fragment_index > track_highest_sent)
                                track_highest_sent = c.fragment_index;
                        end
                        STAT_ACKED:
                        begin
                            frag_sent[idx]  = 1'b1;
                            frag_acked[idx] = 1'b1;
                        end
                        default:    // unsent and nacked both clear the pair
                        begin
                            frag_sent[idx]  = 1'b0;
                            frag_acked[idx] = 1'b0;
                        end
                    endcase
                    add_report(reports, status_report('0, 1'b0, 1'b1, 1'b1));
                end
            end
            OP_RESET_SENT:
            begin
                for (int i = 0; i < n; i++)
                    if (frag_sent[i] && !frag_acked[i])
                        frag_sent[i] = 1'b0;
                add_report(reports, status_report('0, 1'b0, 1'b1, 1'b1));
            end
            OP_LIST:
            begin
                for (int i = 0; i < n && found.size() < LIST_LIMIT; i++)
                    if (!frag_sent[i] && !frag_acked[i])
                        found = {found, i};
                if (found.size() == 0)
                    add_report(reports, status_report('0, 1'b0, 1'b1, 1'b1));
                else
                    foreach (found[k])
                        add_report(reports,
                                   status_report(FRAG_IDX_W'(found[k]), 1'b1,
                                                 k == found.size() - 1, 1'b1));
            end
            default:
                add_report(reports, status_report('0, 1'b0, 1'b1, 1'b1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic step_t cmd_step(logic [1:0] op, logic [1:0] st,
                                       logic [FRAG_IDX_W-1:0] idx);
        step_t s;
        s.is_cfg = 1'b0;
        s.count  = '0;
        s.c      = {op, st, idx};
        s.typed  = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    function automatic step_t typed_step(logic [1:0] op, logic [1:0] st,
                                         logic [FRAG_IDX_W-1:0] idx, rsp_item_t want);
        step_t s;
        s       = cmd_step(op, st, idx);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic step_t cfg_step(logic [CFG_W-1:0] v);
        step_t s;
        s        = cmd_step(OP_QUERY, STAT_UNSENT, '0);
        s.is_cfg = 1'b1;
        s.count  = v;
        return s;
    endfunction

    // single result of a non-list command
    function automatic rsp_item_t summary(int na, int ak, int st, int us,
                                          int ls, int hs, logic acc);
        rsp_item_t r;
        r                 = '0;
        r.last_result     = 1'b1;
        r.accepted        = acc;
        r.not_acked_total = CNT_OUT_W'(na);
        r.acked_total     = CNT_OUT_W'(ak);
        r.sent_total      = CNT_OUT_W'(st);
        r.unsent_total    = CNT_OUT_W'(us);
        r.last_sent       = FRAG_IDX_W'(ls);
        r.highest_sent    = FRAG_IDX_W'(hs);
        return r;
    endfunction

    // weighted mostly toward sets so the table fills and drains
    function automatic cmd_item_t random_command(int unsigned n);
        cmd_item_t   c;
        int unsigned pick;
        c    = cmd_item_t'($urandom);   // unused fields carry noise
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            c.opcode = OP_SET;
            pick     = $urandom_range(0, 99);
            c.new_status = (pick < 40) ? STAT_SENT :
                           (pick < 65) ? STAT_ACKED :
                           (pick < 80) ? STAT_UNSENT : STAT_NACKED;
            if (n > 0 && $urandom_range(0, 99) < 85)
                c.fragment_index = FRAG_IDX_W'($urandom_range(0, n - 1));
        end
        else if (pick < 70)
            c.opcode = OP_RESET_SENT;
        else if (pick < 84)
            c.opcode = OP_LIST;
        else
            c.opcode = OP_QUERY;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    // hold the item until taken, then book its results
    task automatic issue(input cmd_item_t c, input bit typed, input rsp_item_t want);
        rsp_item_t reports[$];
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        apply_command(c, reports);
        if (typed)
            add_report(expected_reports, want);
        else
            foreach (reports[k])
                add_report(expected_reports, reports[k]);
    endtask

    task automatic pause(int unsigned cycles);
        cmd_valid <= 1'b0;
        repeat (cycles)
        begin
            cmd <= cmd_item_t'($urandom);
            @(posedge clk);
        end
    endtask

    // wait for every booked result, then let the ring finish its walk
    task automatic drain();
        cmd_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] v);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        track_count = v;
    endtask

    // ------------------------------------------------------------------
    // Result side: receiver stalls in short runs between free stretches
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (rsp_stall)
        begin
            rsp_stall <= 1'b0;
            hold_left <= ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6)
                                                     : $urandom_range(20, 60);
        end
        else
        begin
            rsp_stall <= 1'b1;
            hold_left <= $urandom_range(0, 3);
        end
    end

    task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_report(rsp_item_t want, rsp_item_t got);
        note_field("listed_index",    32'(want.listed_index),    32'(got.listed_index));
        note_field("index_valid",     32'(want.index_valid),     32'(got.index_valid));
        note_field("last_result",     32'(want.last_result),     32'(got.last_result));
        note_field("accepted",        32'(want.accepted),        32'(got.accepted));
        note_field("not_acked_total", 32'(want.not_acked_total), 32'(got.not_acked_total));
        note_field("acked_total",     32'(want.acked_total),     32'(got.acked_total));
        note_field("sent_total",      32'(want.sent_total),      32'(got.sent_total));
        note_field("unsent_total",    32'(want.unsent_total),    32'(got.unsent_total));
        note_field("last_sent",       32'(want.last_sent),       32'(got.last_sent));
        note_field("highest_sent",    32'(want.highest_sent),    32'(got.highest_sent));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: result expected none, got %p", $time, rsp);
                fault_count++;
            end
            else
                check_report(expected_reports.pop_front(), rsp);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int               phase_count[8];
        int               phase_len[8];
        int unsigned      n;
        int unsigned      burst_left;
        bit               gaps_on;
        logic [CFG_W-1:0] v;

        phase_count = '{64, 1, 0, 127, -1, 65, 2, -1};   // -1: random mid count
        phase_len   = '{70, 50, 20, 60, 80, 60, 50, 90};

        rst_n              = 1'b0;
        cmd_valid          = 1'b0;
        cmd                = '0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        track_count        = 7'd64;
        track_last_sent    = '0;
        track_highest_sent = '0;

        steps = '{
            // fresh table: all 64 unsent, the list runs to its full length
            typed_step(OP_QUERY, STAT_UNSENT, 6'd0, summary(64, 0, 0, 64, 0, 0, 1'b1)),
            cmd_step(OP_LIST, STAT_UNSENT, 6'd0),
            typed_step(OP_SET, STAT_SENT, 6'd63, summary(63, 0, 1, 63, 63, 63, 1'b1)),
            cmd_step(OP_SET, STAT_SENT,   6'd0),     // last moves, highest stays
            cmd_step(OP_SET, STAT_ACKED,  6'd5),
            cmd_step(OP_SET, STAT_NACKED, 6'd63),    // nack clears a sent entry
            cmd_step(OP_SET, STAT_UNSENT, 6'd5),
            cmd_step(OP_SET, STAT_SENT,   6'd10),
            cmd_step(OP_SET, STAT_SENT,   6'd20),
            cmd_step(OP_SET, STAT_ACKED,  6'd20),
            cmd_step(OP_RESET_SENT, STAT_UNSENT, 6'd0),
            cmd_step(OP_LIST, STAT_UNSENT, 6'd0),
            cmd_step(OP_SET, STAT_SENT,   6'd30),    // parked above the next count
            // single fragment: out-of-range set, then an empty list
            cfg_step(7'd1),
            cmd_step(OP_SET, STAT_SENT, 6'd1),
            cmd_step(OP_SET, STAT_SENT, 6'd0),
            cmd_step(OP_LIST, STAT_UNSENT, 6'd0),
            // empty sample: the set is rejected, all counts zero
            cfg_step(7'd0),
            typed_step(OP_SET, STAT_ACKED, 6'd0, summary(0, 0, 0, 0, 0, 63, 1'b0)),
            cmd_step(OP_LIST, STAT_UNSENT, 6'd0),
            cmd_step(OP_RESET_SENT, STAT_UNSENT, 6'd0),
            // count beyond capacity acts as 64; parked flags reappear
            cfg_step(7'd127),
            cmd_step(OP_QUERY, STAT_UNSENT, 6'd0),
            cmd_step(OP_SET, STAT_ACKED, 6'd63),
            cmd_step(OP_LIST, STAT_UNSENT, 6'd0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_count(steps[i].count);
            else
                issue(steps[i].c, steps[i].typed, steps[i].want);
        end

        // random phases, one count each; every third phase sends back to back
        for (int p = 0; p < 8; p++)
        begin
            v = (phase_count[p] < 0) ? CFG_W'($urandom_range(3, 63))
                                     : CFG_W'(phase_count[p]);
            write_count(v);
            n          = live_fragments();
            gaps_on    = (p % 3 != 1);
            burst_left = $urandom_range(1, 12);
            for (int k = 0; k < phase_len[p]; k++)
            begin
                issue(random_command(n), 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    if (gaps_on)
                        pause($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end

        drain();
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fat_pkg.sv
rtl/fat_cell.sv
rtl/fat_ring.sv
rtl/fragment_ack_status_table.sv
test/fragment_ack_status_table_tb.sv
